// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define UTFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// expr must never be true outside reset
`define UTFD_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

// ===== design/utfd_pkg.sv =====
// ----------------------------------------------------------------------------
// utfd_pkg
// Types and constants shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package utfd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] REPL_RESET      = 16'h003F;

    // sequence length codes; zero doubles as "invalid lead" and "idle"
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_1    = 3'd1;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;
    localparam logic [2:0] LEN_5    = 3'd5;
    localparam logic [2:0] LEN_6    = 3'd6;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [30:0] code_point;
        logic        substituted;
        logic        is_error;
        logic        string_end;
    } t_out_item;

    // classified byte handed from front to back
    typedef struct packed {
        logic [2:0] lead_len;   // length if this were a lead byte, LEN_NONE if illegal
        logic [4:0] lead_bits;  // payload bits of a lead byte
        logic       is_cont;    // top bits are 10
        logic       overlong2;  // 2-byte lead with bits 0x1E clear
        logic [7:0] raw;
        logic       last;
    } t_byte_class;

endpackage

// ===== design/utfd_front.sv =====
// ----------------------------------------------------------------------------
// utfd_front
// Input side: takes bytes while the queue has room and classifies them.
// ----------------------------------------------------------------------------
module utfd_front (
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  utfd_pkg::t_in_item    i_in_item,
    input  logic                  i_q_full,
    output logic                  o_push,
    output utfd_pkg::t_byte_class o_push_data
);

    logic [7:0] b;
    logic [2:0] len;

    assign b          = i_in_item.byte_in;
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        priority if (b[7] == 1'b0) begin
            len = utfd_pkg::LEN_1;
        end else if (b[7:5] == 3'b110) begin
            len = utfd_pkg::LEN_2;
        end else if (b[7:4] == 4'b1110) begin
            len = utfd_pkg::LEN_3;
        end else if (b[7:3] == 5'b11110) begin
            len = utfd_pkg::LEN_4;
        end else if (b[7:2] == 6'b111110) begin
            len = utfd_pkg::LEN_5;
        end else if (b[7:1] == 7'b1111110) begin
            len = utfd_pkg::LEN_6;
        end else begin
            len = utfd_pkg::LEN_NONE;
        end
    end

    always_comb begin
        o_push_data.lead_len  = len;
        o_push_data.is_cont   = (b[7:6] == 2'b10);
        o_push_data.overlong2 = (len == utfd_pkg::LEN_2) && (b[4:1] == 4'd0);
        o_push_data.raw       = b;
        o_push_data.last      = i_in_item.last_byte;
        unique case (len)
            utfd_pkg::LEN_2: o_push_data.lead_bits = b[4:0];
            utfd_pkg::LEN_3: o_push_data.lead_bits = {1'b0, b[3:0]};
            utfd_pkg::LEN_4: o_push_data.lead_bits = {2'b0, b[2:0]};
            utfd_pkg::LEN_5: o_push_data.lead_bits = {3'b0, b[1:0]};
            utfd_pkg::LEN_6: o_push_data.lead_bits = {4'b0, b[0]};
            default:         o_push_data.lead_bits = 5'd0;
        endcase
    end

endmodule

// ===== design/utfd_queue.sv =====
// ----------------------------------------------------------------------------
// utfd_queue
// Short first-word-fall-through queue of classified bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_queue #(
    parameter int unsigned DEPTH = utfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  utfd_pkg::t_byte_class i_push_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output utfd_pkg::t_byte_class o_data
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    utfd_pkg::t_byte_class r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    `UTFD_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `UTFD_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && !o_valid, "pop from empty queue")
    `UTFD_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count out of range")

endmodule

// ===== design/utfd_back.sv =====
// ----------------------------------------------------------------------------
// utfd_back
// Sequence state machine and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utfd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  utfd_pkg::t_byte_class i_q_data,
    output logic                  o_pop,
    input  logic [15:0]           i_repl,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output utfd_pkg::t_out_item   o_out_item
);

    logic [2:0]  r_len, n_len;
    logic [2:0]  r_pos, n_pos;
    logic [30:0] r_acc, n_acc;
    logic        r_drop, n_drop;
    logic        r_out_valid;
    utfd_pkg::t_out_item r_out;

    logic        do_err;
    logic        do_char;
    logic [30:0] char_cp;
    logic [30:0] acc_shift;
    logic [2:0]  pos_inc;
    logic [6:0]  ovl3;
    logic        sub;
    utfd_pkg::t_out_item res;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign acc_shift   = {r_acc[24:0], i_q_data.raw[5:0]};
    assign pos_inc     = r_pos + 3'd1;
    assign ovl3        = i_q_data.raw[6:0] >> (3'd7 - r_len);

    always_comb begin
        n_len   = r_len;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_drop  = r_drop;
        do_err  = 1'b0;
        do_char = 1'b0;
        char_cp = '0;
        if (o_pop) begin
            if (r_drop) begin
                if (i_q_data.last) begin
                    n_drop = 1'b0;
                end
            end else if (r_len == utfd_pkg::LEN_NONE) begin
                priority if (i_q_data.lead_len == utfd_pkg::LEN_NONE) begin
                    do_err = 1'b1;
                end else if (i_q_data.lead_len == utfd_pkg::LEN_1) begin
                    do_char = 1'b1;
                    char_cp = {23'd0, i_q_data.raw};
                end else if (i_q_data.overlong2 || i_q_data.last) begin
                    do_err = 1'b1;
                end else begin
                    n_len = i_q_data.lead_len;
                    n_pos = 3'd1;
                    n_acc = {26'd0, i_q_data.lead_bits};
                end
            end else begin
                priority if (!i_q_data.is_cont) begin
                    do_err = 1'b1;
                end else if (r_acc == '0 && r_pos == 3'd2 && ovl3 == '0) begin
                    do_err = 1'b1;
                end else if (pos_inc >= r_len) begin
                    do_char = 1'b1;
                    char_cp = acc_shift;
                end else if (i_q_data.last) begin
                    do_err = 1'b1;
                end else begin
                    n_acc = acc_shift;
                    n_pos = pos_inc;
                end
            end
            if (do_err || do_char) begin
                n_len = utfd_pkg::LEN_NONE;
                n_pos = '0;
                n_acc = '0;
            end
            if (do_err) begin
                n_drop = !i_q_data.last;
            end
        end
    end

    assign sub = |char_cp[30:16];

    always_comb begin
        res = '0;
        if (do_err) begin
            res.is_error   = 1'b1;
            res.string_end = 1'b1;
        end else begin
            res.code_unit   = sub ? i_repl : char_cp[15:0];
            res.code_point  = char_cp;
            res.substituted = sub;
            res.string_end  = i_q_data.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= utfd_pkg::LEN_NONE;
            r_pos       <= '0;
            r_acc       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_pos  <= n_pos;
            r_acc  <= n_acc;
            r_drop <= n_drop;
            if (do_err || do_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_err || do_char) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `UTFD_ASSERT(a_drop_after_err, i_clk, i_rst_n, $rose(r_drop) |-> (r_out_valid && r_out.is_error), "drop mode entered without error result")
    `UTFD_ASSERT(a_err_fields, i_clk, i_rst_n, (r_out_valid && r_out.is_error) |-> (r_out.code_point == '0 && r_out.string_end), "error result carries code data")
    `UTFD_ASSERT(a_sub_range, i_clk, i_rst_n, (r_out_valid && r_out.substituted) |-> (r_out.code_point > 31'h0000FFFF), "substitution below 0x10000")

endmodule

// ===== design/utf8_to_wide_char_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_wide_char_decoder_top
// UTF-8 byte stream to code point and 16-bit code unit decoder.
// ----------------------------------------------------------------------------
// Takes one byte per item (last_byte flags the end of a string) and returns one
// result per completed character of 1 to 6 bytes, or one error result on an
// illegal lead, a bad continuation byte, an overlong form or a string that ends
// mid-sequence; after an error the rest of the string is dropped silently.
// Throughput is one byte per clock while the output is not stalled, set by the
// sequence state update in the back end; a result is registered in the output
// register once its final byte has passed through the queue and the back end.
// The queue between front and back holds QUEUE_DEPTH classified bytes, so
// input and output stall independently. The replacement code unit (reset 0x3F)
// is written through the cfg channel, always ready; write it only while idle.
// ----------------------------------------------------------------------------
module utf8_to_wide_char_decoder_top #(
    parameter int unsigned QUEUE_DEPTH = utfd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  utfd_pkg::t_in_item  i_in_item,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output utfd_pkg::t_out_item o_out_item,
    // replacement character register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic                  q_full;
    logic                  q_push;
    utfd_pkg::t_byte_class q_push_data;
    logic                  q_valid;
    logic                  q_pop;
    utfd_pkg::t_byte_class q_data;
    logic [15:0]           r_repl;

    // config write always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repl <= utfd_pkg::REPL_RESET;
        end else if (i_cfg_valid) begin
            r_repl <= i_cfg_data;
        end
    end

    // front: accept and classify
    utfd_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // decoupling queue
    utfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // back: sequence decode and result register
    utfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_pop       (q_pop),
        .i_repl      (r_repl),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/sv/utf8_to_wide_char_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_wide_char_decoder_top_tb
// Self-checking bench for the UTF-8 to code point / code unit decoder.
// ----------------------------------------------------------------------------
// Strings are fed one byte per item. Every accepted byte goes through a
// cycle-free model of the decoder that queues the result it should produce;
// every accepted result is checked field by field against the oldest queued
// one. A short directed set covers the corner cases, then three random phases
// run with different idle mixes and replacement character values, one of them
// with a long output stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module utf8_to_wide_char_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_BYTES   = 330;
    localparam int MAX_REPORTS   = 10;

    typedef logic [7:0] t_byte_seq[$];

    // ------------------------------------------------------------------------
    // Decoder model and expected result store
    // ------------------------------------------------------------------------
    class decode_scoreboard;
        logic [15:0] repl_char = utfd_pkg::REPL_RESET;
        logic [2:0]  seq_len   = utfd_pkg::LEN_NONE;
        logic [2:0]  seq_pos   = '0;
        logic [30:0] acc       = '0;
        bit          dropping  = 1'b0;
        int          decoded_bytes = 0;
        int          mismatches    = 0;
        utfd_pkg::t_out_item expected_q[$];

        function void clear_seq();
            seq_len = utfd_pkg::LEN_NONE;
            seq_pos = '0;
            acc     = '0;
        endfunction

        function void queue_error(logic fin);
            utfd_pkg::t_out_item r;
            clear_seq();
            dropping     = !fin;
            r            = '0;
            r.is_error   = 1'b1;
            r.string_end = 1'b1;
            expected_q.push_back(r);
        endfunction

        function void queue_char(logic [30:0] cp, logic fin);
            utfd_pkg::t_out_item r;
            logic                sub;
            sub = (cp > 31'hFFFF);
            clear_seq();
            r.code_unit   = sub ? repl_char : cp[15:0];
            r.code_point  = cp;
            r.substituted = sub;
            r.is_error    = 1'b0;
            r.string_end  = fin;
            expected_q.push_back(r);
        endfunction

        // called for every byte the block accepts
        function void note_byte(utfd_pkg::t_in_item it);
            logic [7:0] b;
            logic       fin;
            logic [2:0] len;
            b   = it.byte_in;
            fin = it.last_byte;
            if (dropping) begin
                if (fin) dropping = 1'b0;
                return;
            end
            decoded_bytes++;
            if (seq_len == utfd_pkg::LEN_NONE) begin
                casez (b)
                    8'b0???????: len = utfd_pkg::LEN_1;
                    8'b110?????: len = utfd_pkg::LEN_2;
                    8'b1110????: len = utfd_pkg::LEN_3;
                    8'b11110???: len = utfd_pkg::LEN_4;
                    8'b111110??: len = utfd_pkg::LEN_5;
                    8'b1111110?: len = utfd_pkg::LEN_6;
                    default:     len = utfd_pkg::LEN_NONE;
                endcase
                if (len == utfd_pkg::LEN_NONE) begin
                    queue_error(fin);
                end else if (len == utfd_pkg::LEN_1) begin
                    queue_char(31'(b), fin);
                end else if (len == utfd_pkg::LEN_2 && (b & 8'h1E) == 8'h00) begin
                    queue_error(fin);
                end else if (fin) begin
                    queue_error(fin);
                end else begin
                    seq_len = len;
                    seq_pos = 3'd1;
                    acc     = 31'((8'hFF >> (len + 1)) & b);
                end
            end else if (b[7:6] != 2'b10) begin
                queue_error(fin);
            end else if (acc == '0 && seq_pos == 3'd2 &&
                         ((b & 8'h7F) >> (7 - seq_len)) == 8'h00) begin
                queue_error(fin);
            end else begin
                acc     = {acc[24:0], b[5:0]};
                seq_pos = seq_pos + 3'd1;
                if (seq_pos >= seq_len) queue_char(acc, fin);
                else if (fin) queue_error(fin);
            end
        endfunction

        // called for every result the block hands over
        function void check_char(utfd_pkg::t_out_item got);
            utfd_pkg::t_out_item want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: unit %h point %h sub %b err %b end %b",
                             got.code_unit, got.code_point, got.substituted,
                             got.is_error, got.string_end);
                return;
            end
            want = expected_q.pop_front();
            if (got.code_unit !== want.code_unit || got.code_point !== want.code_point ||
                got.substituted !== want.substituted || got.is_error !== want.is_error ||
                got.string_end !== want.string_end) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: want unit %h point %h sub %b err %b end %b,",
                              " got unit %h point %h sub %b err %b end %b"},
                             want.code_unit, want.code_point, want.substituted,
                             want.is_error, want.string_end, got.code_unit,
                             got.code_point, got.substituted, got.is_error,
                             got.string_end);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    utfd_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    utfd_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data  = '0;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int out_hold_cycles = 0;
    int cycle_count     = 0;

    decode_scoreboard sb = new();

    utf8_to_wide_char_decoder_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit; a healthy run ends far earlier than this.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("utf8_to_wide_char_decoder_top_tb failed");
        $finish;
    end

    // Every handshake is sampled at the rising edge; TB drives only on the
    // falling edge, so the values seen here are stable.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.repl_char = cfg_data;
            if (in_valid && in_ready) sb.note_byte(in_item);
            if (out_valid && out_ready) sb.check_char(out_item);
        end
    end

    // Result side: random back-pressure, or a forced hold-off while
    // out_hold_cycles counts down.
    always @(negedge clk) begin
        if (out_hold_cycles > 0) begin
            out_hold_cycles--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One byte item; random idle cycles ahead of it, valid held until taken.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= '{byte_in: b, last_byte: fin};
        do @(posedge clk); while (!in_ready);
    endtask

    // A whole string; last_byte rides on its final byte.
    task automatic send_string(input t_byte_seq s);
        foreach (s[i]) push_byte(s[i], i == s.size() - 1);
    endtask

    // Let everything in flight come out, then give trailing bytes that make no
    // result time to leave the pipeline.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Replacement character write; only called with the block idle.
    task automatic write_repl(input logic [15:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed strings of 1..6 characters with random code points
    // (some shrunk so that overlong forms show up), plus some broken ones.
    function automatic t_byte_seq random_string();
        t_byte_seq   s;
        int          len;
        int          bits;
        int          pick;
        logic [30:0] cp;
        // pure noise
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(255)));
            return s;
        end
        repeat ($urandom_range(1, 6)) begin
            pick = $urandom_range(99);
            len  = pick < 40 ? 1 : pick < 60 ? 2 : pick < 75 ? 3 :
                   pick < 87 ? 4 : pick < 94 ? 5 : 6;
            bits = (len == 1) ? 7 : 5 * len + 1;
            cp   = 31'($urandom()) & ((31'd1 << bits) - 31'd1);
            if ($urandom_range(3) == 0) cp = cp >> $urandom_range(bits);
            if (len == 1) begin
                s.push_back({1'b0, cp[6:0]});
            end else begin
                s.push_back(8'(8'hFF << (8 - len)) | 8'(cp >> (6 * (len - 1))));
                for (int k = len - 2; k >= 0; k--)
                    s.push_back({2'b10, 6'(cp >> (6 * k))});
            end
        end
        // break some strings: a stray byte, a cut tail, or an extra byte
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(2))
                0:       s[$urandom_range(s.size() - 1)] = 8'($urandom_range(255));
                1:       if (s.size() > 1) s.delete(s.size() - 1);
                default: s.push_back(8'($urandom_range(255)));
            endcase
        end
        return s;
    endfunction

    // One random phase: idle mix, then strings until enough bytes were decoded
    // (dropped bytes do not count). With squeeze set the output is held off
    // for a long stretch partway through.
    task automatic run_phase(input int send_pct, input int recv_pct, input bit squeeze);
        int start;
        bit held;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start         = sb.decoded_bytes;
        held          = 1'b0;
        while (sb.decoded_bytes - start < PHASE_BYTES) begin
            if (squeeze && !held && sb.decoded_bytes - start >= PHASE_BYTES / 3) begin
                out_hold_cycles = 300;
                held            = 1'b1;
            end
            send_string(random_string());
        end
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        // synchronous reset
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings, reset replacement value, sender mostly busy,
        // receiver mostly stalled
        send_idle_pct = 10;
        recv_idle_pct = 88;
        // NUL, top ASCII, two-byte, four-byte (substituted)
        send_string('{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80});
        // overlong two-byte lead, rest of string dropped
        send_string('{8'hC0, 8'h41});
        // continuation byte in lead position
        send_string('{8'h80});
        // overlong third byte
        send_string('{8'hE0, 8'h80, 8'h80});
        // non-continuation after lead
        send_string('{8'hC3, 8'h41});
        // string ends mid-sequence
        send_string('{8'hE2, 8'h82});
        // longest legal sequence, code point 0x7FFFFFFF
        send_string('{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF});
        // never-legal lead
        send_string('{8'hFF});
        settle();

        // Sender mostly busy, receiver mostly stalled
        write_repl(16'hFFFF);
        run_phase(10, 88, 1'b0);

        // Sender mostly idle, receiver mostly ready
        write_repl(16'h0000);
        run_phase(88, 10, 1'b0);

        // No idling, with one long output hold-off to fill the block
        write_repl(16'($urandom_range(1, 16'hFFFE)));
        run_phase(0, 0, 1'b1);

        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("utf8_to_wide_char_decoder_top_tb passed");
        else
            $display("utf8_to_wide_char_decoder_top_tb failed");
        $finish;
    end

endmodule
